FILE: rtl/core/lcabl_pkg.sv
// ----------------------------------------------------------------------------
// LCA binary lifting package
// Shared types, widths and codes for the lowest common ancestor engine.
// ----------------------------------------------------------------------------
package lcabl_pkg;

    localparam int NODE_W        = 10;
    localparam int GAP_W         = 12;
    localparam int CNT_W         = 11;
    localparam int MAX_NODES_DEF = 1024;
    localparam int LEVELS_DEF    = 10;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_BUILD = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] parent;
        logic [NODE_W-1:0] node_depth;
        logic [NODE_W-1:0] other_node;
    } lcabl_cmd_t;

    typedef struct packed {
        logic [NODE_W-1:0]       ancestor;
        logic signed [GAP_W-1:0] gap;
    } lcabl_result_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_B_RD0,
        ST_B_RD1,
        ST_B_WR,
        ST_Q_DA,
        ST_Q_DB,
        ST_Q_ORD,
        ST_Q_LIFT,
        ST_Q_LIFT_W,
        ST_Q_CMP,
        ST_Q_UP_A,
        ST_Q_UP_B,
        ST_Q_UP_C,
        ST_Q_PAR,
        ST_Q_PAR_W,
        ST_Q_DL,
        ST_Q_DL_W
    } lcabl_state_t;

endpackage

FILE: rtl/core/lca_binary_lifting.sv
// ----------------------------------------------------------------------------
// LCA binary lifting engine
// Lowest common ancestor and path length over a tree held in on-chip RAM.
// ----------------------------------------------------------------------------
// A node write leaves busy low. A table build holds busy while it makes one
// ancestor RAM read pair and one write for each of min(node_count, MAX_NODES)
// * (LEVELS - 1) entries. A query holds busy while it reads the ancestor RAM
// level by level through its single read port, and its beat appears on done
// in the first cycle with busy low. The receiver cannot stall.
// Reset clears control and sets node_count to 1024; the RAMs are not cleared.
module lca_binary_lifting #(
    parameter int MAX_NODES = lcabl_pkg::MAX_NODES_DEF,
    parameter int LEVELS    = lcabl_pkg::LEVELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  lcabl_pkg::lcabl_cmd_t           cmd,
    output logic                            done,
    output lcabl_pkg::lcabl_result_t        result,
    input  logic                            cfg_we,
    input  logic [lcabl_pkg::CNT_W-1:0]     cfg_wdata
);

    import lcabl_pkg::*;

    localparam int NW   = $clog2(MAX_NODES);
    localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int AW   = LW + NW;
    localparam int CMPW = (NW + 1 > CNT_W) ? NW + 1 : CNT_W;

    localparam logic [NODE_W-1:0] LIFT_MASK =
        (LEVELS >= NODE_W) ? {NODE_W{1'b1}} : NODE_W'((1 << LEVELS) - 1);
    localparam logic [LW-1:0]   TOP_LVL = LW'(LEVELS - 1);
    localparam logic [CMPW-1:0] MAX_CNT = CMPW'(MAX_NODES);

    function automatic logic in_range(input logic [NODE_W-1:0] x);
        return (32'(x) < 32'(MAX_NODES));
    endfunction

    lcabl_state_t state_reg, state_next;

    logic [CNT_W-1:0]  node_count_reg;
    logic [NODE_W-1:0] a_reg, a_next;
    logic [NODE_W-1:0] b_reg, b_next;
    logic [NODE_W-1:0] t_reg, t_next;
    logic [NODE_W-1:0] da_reg, da_next;
    logic [NODE_W-1:0] db_reg, db_next;
    logic [NODE_W-1:0] lift_reg, lift_next;
    logic [LW-1:0]     lvl_reg, lvl_next;
    logic [NW-1:0]     i_reg, i_next;
    logic              anc_oor_reg, dep_oor_reg;
    logic              done_reg, done_next;
    lcabl_result_t     result_reg, result_next;

    logic [CMPW-1:0]   count_ext, count_eff;
    logic              last_i;

    logic              anc_we, anc_re, dep_we, dep_re;
    logic [AW-1:0]     anc_waddr, anc_raddr;
    logic [NODE_W-1:0] anc_wdata, anc_rdata, dep_rdata;
    logic [NODE_W-1:0] anc_rnode, dep_rnode;
    logic [LW-1:0]     anc_rlvl;
    logic [NODE_W-1:0] anc_q, dep_q;
    logic [GAP_W-1:0]  gap_calc;

    assign count_ext = CMPW'(node_count_reg);
    assign count_eff = (count_ext > MAX_CNT) ? MAX_CNT : count_ext;
    assign last_i    = (CMPW'(i_reg) + CMPW'(1)) == count_eff;
    assign anc_q     = anc_oor_reg ? '0 : anc_rdata;
    assign dep_q     = dep_oor_reg ? '0 : dep_rdata;
    assign anc_raddr = {anc_rlvl, NW'(anc_rnode)};
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;

    assign gap_calc = GAP_W'(da_reg) + GAP_W'(db_reg) - (GAP_W'(dep_q) << 1) - GAP_W'(1);

    lcabl_ram #(
        .WIDTH (NODE_W),
        .DEPTH (2 ** AW)
    ) u_anc_ram (
        .clk   (clk),
        .we    (anc_we),
        .waddr (anc_waddr),
        .wdata (anc_wdata),
        .re    (anc_re),
        .raddr (anc_raddr),
        .rdata (anc_rdata)
    );

    lcabl_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_dep_ram (
        .clk   (clk),
        .we    (dep_we),
        .waddr (NW'(cmd.node)),
        .wdata (cmd.node_depth),
        .re    (dep_re),
        .raddr (NW'(dep_rnode)),
        .rdata (dep_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.action)
                        ACT_BUILD:
                        begin
                            if (count_eff != '0 && LEVELS > 1)
                            begin
                                state_next = ST_B_RD0;
                            end
                        end
                        ACT_QUERY: state_next = ST_Q_DA;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_B_RD0: state_next = ST_B_RD1;
            ST_B_RD1: state_next = ST_B_WR;
            ST_B_WR:
            begin
                if (last_i && lvl_reg == TOP_LVL)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_B_RD0;
                end
            end
            ST_Q_DA:  state_next = ST_Q_DB;
            ST_Q_DB:  state_next = ST_Q_ORD;
            ST_Q_ORD: state_next = ST_Q_LIFT;
            ST_Q_LIFT:
            begin
                if (lift_reg == '0)
                begin
                    state_next = ST_Q_CMP;
                end
                else if (lift_reg[0])
                begin
                    state_next = ST_Q_LIFT_W;
                end
            end
            ST_Q_LIFT_W: state_next = ST_Q_LIFT;
            ST_Q_CMP:    state_next = (a_reg == b_reg) ? ST_Q_DL : ST_Q_UP_A;
            ST_Q_UP_A:   state_next = ST_Q_UP_B;
            ST_Q_UP_B:   state_next = ST_Q_UP_C;
            ST_Q_UP_C:   state_next = (lvl_reg == '0) ? ST_Q_PAR : ST_Q_UP_A;
            ST_Q_PAR:    state_next = ST_Q_PAR_W;
            ST_Q_PAR_W:  state_next = ST_Q_DL;
            ST_Q_DL:     state_next = ST_Q_DL_W;
            ST_Q_DL_W:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        anc_we    = 1'b0;
        anc_waddr = {lvl_reg, i_reg};
        anc_wdata = anc_q;
        dep_we    = 1'b0;
        anc_re    = 1'b0;
        anc_rnode = a_reg;
        anc_rlvl  = lvl_reg;
        dep_re    = 1'b0;
        dep_rnode = a_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                anc_waddr = {LW'(0), NW'(cmd.node)};
                anc_wdata = cmd.parent;
                if (start && cmd.action == ACT_WRITE && in_range(cmd.node))
                begin
                    anc_we = 1'b1;
                    dep_we = 1'b1;
                end
            end
            ST_B_RD0:
            begin
                anc_rnode = NODE_W'(i_reg);
                anc_rlvl  = lvl_reg - LW'(1);
                anc_re    = 1'b1;
            end
            ST_B_RD1:
            begin
                anc_rnode = anc_q;
                anc_rlvl  = lvl_reg - LW'(1);
                anc_re    = in_range(anc_q);
            end
            ST_B_WR:  anc_we = 1'b1;
            ST_Q_DA:  dep_re = in_range(a_reg);
            ST_Q_DB:
            begin
                dep_rnode = b_reg;
                dep_re    = in_range(b_reg);
            end
            ST_Q_LIFT: anc_re = lift_reg[0] && in_range(a_reg);
            ST_Q_UP_A: anc_re = in_range(a_reg);
            ST_Q_UP_B:
            begin
                anc_rnode = b_reg;
                anc_re    = in_range(b_reg);
            end
            ST_Q_PAR:
            begin
                anc_rlvl = '0;
                anc_re   = in_range(a_reg);
            end
            ST_Q_DL: dep_re = in_range(a_reg);
            default:
            begin
                anc_re = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        t_next      = t_reg;
        da_next     = da_reg;
        db_next     = db_reg;
        lift_next   = lift_reg;
        lvl_next    = lvl_reg;
        i_next      = i_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                a_next   = cmd.node;
                b_next   = cmd.other_node;
                lvl_next = LW'(1);
                i_next   = '0;
            end
            ST_B_WR:
            begin
                if (last_i)
                begin
                    i_next   = '0;
                    lvl_next = lvl_reg + LW'(1);
                end
                else
                begin
                    i_next = i_reg + NW'(1);
                end
            end
            ST_Q_DB: da_next = dep_q;
            ST_Q_ORD:
            begin
                db_next  = dep_q;
                lvl_next = '0;
                if (da_reg < dep_q)
                begin
                    a_next    = b_reg;
                    b_next    = a_reg;
                    lift_next = (dep_q - da_reg) & LIFT_MASK;
                end
                else
                begin
                    lift_next = (da_reg - dep_q) & LIFT_MASK;
                end
            end
            ST_Q_LIFT:
            begin
                if (lift_reg != '0 && !lift_reg[0])
                begin
                    lift_next = lift_reg >> 1;
                    lvl_next  = lvl_reg + LW'(1);
                end
            end
            ST_Q_LIFT_W:
            begin
                a_next    = anc_q;
                lift_next = lift_reg >> 1;
                lvl_next  = lvl_reg + LW'(1);
            end
            ST_Q_CMP: lvl_next = TOP_LVL;
            ST_Q_UP_B: t_next = anc_q;
            ST_Q_UP_C:
            begin
                if (t_reg != anc_q)
                begin
                    a_next = t_reg;
                    b_next = anc_q;
                end
                lvl_next = lvl_reg - LW'(1);
            end
            ST_Q_PAR_W: a_next = anc_q;
            ST_Q_DL_W:
            begin
                done_next            = 1'b1;
                result_next.ancestor = a_reg;
                result_next.gap      = $signed(gap_calc);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NODE_COUNT_RST;
            done_reg       <= 1'b0;
            anc_oor_reg    <= 1'b0;
            dep_oor_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            anc_oor_reg <= !in_range(anc_rnode);
            dep_oor_reg <= !in_range(dep_rnode);
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        t_reg      <= t_next;
        da_reg     <= da_next;
        db_reg     <= db_next;
        lift_reg   <= lift_next;
        lvl_reg    <= lvl_next;
        i_reg      <= i_next;
        result_reg <= result_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_Q_DL_W))
        else $error("Result beat without a finished query.");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Result beat while the engine is still busy.");

    assert property (@(posedge clk) disable iff (!rst_n)
        anc_we |-> (state_reg == ST_IDLE || state_reg == ST_B_WR))
        else $error("Ancestor RAM written outside a node write or table build.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_B_WR) |-> (lvl_reg != '0))
        else $error("Table build writing the parent level.");

endmodule

FILE: rtl/core/lcabl_ram.sv
// ----------------------------------------------------------------------------
// LCA binary lifting RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lcabl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
